// ===== hdl/ops_pkg.sv =====
// ----------------------------------------------------------------------------
// ops_pkg
// shared types and codes for the oscillating probe step sequencer
// ----------------------------------------------------------------------------
package ops_pkg;

  localparam int MAX_STEPS_DEFAULT = 64;

  // item commands
  localparam logic [2:0] CMD_LOAD_ORD  = 3'd0;
  localparam logic [2:0] CMD_LOAD_SD   = 3'd1;
  localparam logic [2:0] CMD_START     = 3'd2;
  localparam logic [2:0] CMD_NEXT      = 3'd3;
  localparam logic [2:0] CMD_TRIGGER   = 3'd4;

  // result status codes
  localparam logic [1:0] STAT_RUNNING  = 2'd0;
  localparam logic [1:0] STAT_STOPPED  = 2'd1;
  localparam logic [1:0] STAT_OVERRAN  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_STEPS     = 2'd0;
  localparam logic [1:0] REG_TICKS     = 2'd1;
  localparam logic [1:0] REG_PERIOD    = 2'd2;
  localparam logic [1:0] REG_MAX_SD    = 2'd3;

  // control from the sequencer to the step-time tables
  typedef struct packed {
    logic wr_ord;
    logic wr_sd;
    logic rd_en;
    logic rd_sd;
  } tbl_ctl_t;

endpackage

// ===== hdl/ops_mul.sv =====
// ----------------------------------------------------------------------------
// ops_mul
// shared 32x32 multiplier, low word of the product registered
// ----------------------------------------------------------------------------
module ops_mul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic [63:0] full;

  assign full = a * b;

  always_ff @(posedge clk) begin
    if (en) begin
      p <= full[31:0];
    end
  end

endmodule

// ===== hdl/ops_tables.sv =====
// ----------------------------------------------------------------------------
// ops_tables
// ordinary and step-down step-time tables, one write and one registered read
// ----------------------------------------------------------------------------
module ops_tables #(
  parameter int MAX_STEPS = 64
) (
  input  logic                             clk,
  input  ops_pkg::tbl_ctl_t                ctl,
  input  logic [6:0]                       wr_addr,
  input  logic [31:0]                      wr_data,
  input  logic [$clog2(MAX_STEPS+1)-1:0]   rd_addr,
  output logic [31:0]                      rd_data
);
  import ops_pkg::*;

  localparam int SAW = $clog2(MAX_STEPS + 1);
  localparam int OAW = $clog2(MAX_STEPS);
  localparam int WW  = (SAW > 7) ? SAW : 7;

  logic [31:0]    ord_mem [MAX_STEPS];
  logic [31:0]    sd_mem  [MAX_STEPS+1];
  logic [WW-1:0]  wa;
  logic [SAW-1:0] ord_sel;
  logic [SAW-1:0] sd_sel;
  logic           ord_in_range;
  logic           sd_in_range;

  assign wa           = WW'(wr_addr);
  assign ord_in_range = 32'(wr_addr) < 32'(MAX_STEPS);
  assign sd_in_range  = 32'(wr_addr) < 32'(MAX_STEPS + 1);

  // wrap the step index into each table
  assign ord_sel = (32'(rd_addr) >= 32'(MAX_STEPS)) ? rd_addr - SAW'(MAX_STEPS) : rd_addr;
  assign sd_sel  = (32'(rd_addr) >= 32'(MAX_STEPS + 1)) ?
                   rd_addr - SAW'(MAX_STEPS + 1) : rd_addr;

  always_ff @(posedge clk) begin
    if (ctl.wr_ord && ord_in_range) begin
      ord_mem[wa[OAW-1:0]] <= wr_data;
    end
    if (ctl.wr_sd && sd_in_range) begin
      sd_mem[wa[SAW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      if (ctl.rd_sd) begin
        rd_data <= sd_mem[sd_sel];
      end else begin
        rd_data <= ord_mem[ord_sel[OAW-1:0]];
      end
    end
  end

endmodule

// ===== hdl/oscillating_probe_step_sequencer.sv =====
// path from accept to result valid: a next step that gives a step time runs exec, mul1,
//   add1, mul2, add2, out; start runs exec, fetch, out; loads, trigger, unknown commands
//   and a next step with no step run exec, out; one transaction at a time, with two passes
//   through the shared multiplier for a timed next step; a stalled result side holds out
// reset: synchronous, clears counters, run mode (stopped) and config to defaults;
//   table contents are not cleared and hold nothing until loaded
// ----------------------------------------------------------------------------
// oscillating_probe_step_sequencer
// step times and directions for a probe axis oscillating in half-cycles,
// with an extra downward step every few half-cycles
// ----------------------------------------------------------------------------
module oscillating_probe_step_sequencer #(
  parameter int MAX_STEPS = ops_pkg::MAX_STEPS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  // input items
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [2:0]  cmd,
  input  logic [6:0]  table_index,
  input  logic [31:0] table_value,
  // results
  output logic        result_valid,
  input  logic        result_stall,
  output logic [31:0] step_time,
  output logic        forwards,
  output logic [1:0]  status
);
  import ops_pkg::*;

  localparam int SW = $clog2(MAX_STEPS + 1);

  // sequencer states
  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_EXEC  = 8'b0000_0010,
    ST_FETCH = 8'b0000_0100,
    ST_MUL1  = 8'b0000_1000,
    ST_ADD1  = 8'b0001_0000,
    ST_MUL2  = 8'b0010_0000,
    ST_ADD2  = 8'b0100_0000,
    ST_OUT   = 8'b1000_0000
  } state_t;

  // run mode of the probe
  typedef enum logic [3:0] {
    MODE_STOPPED  = 4'b0001,
    MODE_NORMAL   = 4'b0010,
    MODE_STOPPING = 4'b0100,
    MODE_OVERRAN  = 4'b1000
  } mode_t;

  state_t state;
  state_t state_next;

  // configuration registers
  logic [6:0]  steps_per_half_cycle;
  logic [31:0] half_cycle_ticks;
  logic [15:0] half_cycles_per_step_down;
  logic [15:0] max_step_downs;

  // run state
  logic [SW-1:0] step_in_half_cycle;
  logic [15:0]   half_cycle_count;
  logic [15:0]   step_downs_done;
  logic          stepping_down;
  mode_t         run_mode;

  logic [SW-1:0] step_next;
  logic [15:0]   hcc_next;
  logic [15:0]   sdd_next;
  logic          sd_next;
  mode_t         mode_next;
  logic          produce;

  // latched transaction and datapath registers
  logic [2:0]  cmd_r;
  logic [6:0]  idx_r;
  logic [31:0] val_r;
  logic [31:0] acc;
  logic [31:0] t_r;

  // advance helpers
  logic [SW-1:0] eff;
  logic [SW:0]   limit;
  logic [SW:0]   s1;
  logic [15:0]   h1;
  logic [15:0]   sdd_inc;

  // shared multiplier and tables
  logic          mul_en;
  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  logic [31:0]   mul_p;
  tbl_ctl_t      tctl;
  logic [SW-1:0] rd_addr;
  logic [31:0]   rd_data;

  logic          accept;
  logic          out_load;
  logic [1:0]    status_now;

  assign cfg_ready  = 1'b1;
  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_load   = (state == ST_OUT) && (!result_valid || !result_stall);

  // effective half-cycle length, clamped to 1..MAX_STEPS
  always_comb begin
    if (steps_per_half_cycle == 7'd0) begin
      eff = SW'(1);
    end else if (32'(steps_per_half_cycle) > 32'(MAX_STEPS)) begin
      eff = SW'(MAX_STEPS);
    end else begin
      eff = SW'(steps_per_half_cycle);
    end
  end

  assign limit   = {1'b0, eff} + (SW+1)'(stepping_down);
  assign s1      = {1'b0, step_in_half_cycle} + (SW+1)'(1);
  assign h1      = half_cycle_count + 16'd1;
  assign sdd_inc = stepping_down ? step_downs_done + 16'd1 : step_downs_done;

  // one step of the oscillation: end of half-cycle, stop, step-down, overrun
  always_comb begin
    step_next = step_in_half_cycle;
    hcc_next  = half_cycle_count;
    sdd_next  = step_downs_done;
    sd_next   = stepping_down;
    mode_next = run_mode;
    produce   = 1'b0;
    if (run_mode == MODE_NORMAL || run_mode == MODE_STOPPING) begin
      produce = 1'b1;
      if (s1 >= limit) begin
        step_next = '0;
        hcc_next  = h1;
        if (run_mode == MODE_STOPPING && !h1[0]) begin
          // stopping finishes on an even half-cycle
          mode_next = MODE_STOPPED;
          produce   = 1'b0;
        end else begin
          sdd_next = sdd_inc;
          sd_next  = 1'b0;
          if (h1 == half_cycles_per_step_down) begin
            if (sdd_inc == max_step_downs) begin
              mode_next = MODE_OVERRAN;
              produce   = 1'b0;
            end else begin
              hcc_next = '0;
              sd_next  = 1'b1;
            end
          end
        end
      end else begin
        step_next = s1[SW-1:0];
      end
    end
  end

  always_comb begin
    unique case (run_mode)
      MODE_STOPPED: status_now = STAT_STOPPED;
      MODE_OVERRAN: status_now = STAT_OVERRAN;
      default:      status_now = STAT_RUNNING;
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd_r)
          CMD_START: state_next = ST_FETCH;
          CMD_NEXT:  state_next = produce ? ST_MUL1 : ST_OUT;
          default:   state_next = ST_OUT;
        endcase
      end
      ST_FETCH: state_next = ST_OUT;
      ST_MUL1:  state_next = ST_ADD1;
      ST_ADD1:  state_next = ST_MUL2;
      ST_MUL2:  state_next = ST_ADD2;
      ST_ADD2:  state_next = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // table control: loads in exec, entry 0 on start, step entry once counters settle
  always_comb begin
    tctl    = '0;
    rd_addr = step_in_half_cycle;
    if (state == ST_EXEC) begin
      tctl.wr_ord = (cmd_r == CMD_LOAD_ORD);
      tctl.wr_sd  = (cmd_r == CMD_LOAD_SD);
      if (cmd_r == CMD_START) begin
        tctl.rd_en = 1'b1;
        rd_addr    = '0;
      end
    end else if (state == ST_MUL1) begin
      tctl.rd_en = 1'b1;
      tctl.rd_sd = stepping_down;
    end
  end

  // multiplier operands: first (period * step-downs), then (base * ticks)
  always_comb begin
    mul_en = (state == ST_MUL1) || (state == ST_MUL2);
    if (state == ST_MUL2) begin
      mul_a = acc;
      mul_b = half_cycle_ticks;
    end else begin
      mul_a = {16'd0, half_cycles_per_step_down};
      mul_b = {16'd0, step_downs_done};
    end
  end

  ops_mul u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  ops_tables #(
    .MAX_STEPS (MAX_STEPS)
  ) u_tables (
    .clk     (clk),
    .ctl     (tctl),
    .wr_addr (idx_r),
    .wr_data (val_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state                     <= ST_IDLE;
      steps_per_half_cycle      <= 7'd1;
      half_cycle_ticks          <= 32'd1;
      half_cycles_per_step_down <= 16'd4;
      max_step_downs            <= 16'd0;
      step_in_half_cycle        <= '0;
      half_cycle_count          <= '0;
      step_downs_done           <= '0;
      stepping_down             <= 1'b0;
      run_mode                  <= MODE_STOPPED;
      result_valid              <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_STEPS:  steps_per_half_cycle      <= cfg_data[6:0];
          REG_TICKS:  half_cycle_ticks          <= cfg_data;
          REG_PERIOD: half_cycles_per_step_down <= cfg_data[15:0];
          REG_MAX_SD: max_step_downs            <= cfg_data[15:0];
          default:    ;
        endcase
      end
      if (state == ST_EXEC) begin
        unique case (cmd_r)
          CMD_START: begin
            step_in_half_cycle <= '0;
            half_cycle_count   <= '0;
            step_downs_done    <= '0;
            stepping_down      <= 1'b0;
            run_mode           <= MODE_NORMAL;
          end
          CMD_NEXT: begin
            step_in_half_cycle <= step_next;
            half_cycle_count   <= hcc_next;
            step_downs_done    <= sdd_next;
            stepping_down      <= sd_next;
            run_mode           <= mode_next;
          end
          CMD_TRIGGER: begin
            if (run_mode == MODE_NORMAL) begin
              run_mode <= MODE_STOPPING;
            end
          end
          default: ;
        endcase
      end
      // result register: a finished transaction refills it, a taken one frees it
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd;
      idx_r <= table_index;
      val_r <= table_value;
    end
    unique case (state)
      ST_EXEC:  t_r <= '0;
      ST_FETCH: t_r <= rd_data;
      ST_ADD1:  acc <= mul_p + {16'd0, half_cycle_count};
      ST_ADD2:  t_r <= mul_p + rd_data;
      default:  ;
    endcase
    if (out_load) begin
      step_time <= t_r;
      forwards  <= half_cycle_count[0];
      status    <= status_now;
    end
  end

  // a step-down half-cycle always starts from half-cycle zero
  a_stepdown_restart: assert property (@(posedge clk) disable iff (rst)
    $rose(stepping_down) |-> half_cycle_count == 16'd0)
    else $error("step-down entered with nonzero half-cycle count");

  // step counter stays inside the longer table
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    step_in_half_cycle <= SW'(MAX_STEPS))
    else $error("step counter beyond table depth");

  // a stopped probe never reports a step time
  a_stopped_no_time: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == STAT_STOPPED |-> step_time == 32'd0)
    else $error("step time given while stopped");

  // an accepted transaction is decoded in the next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("accepted transaction not executed");

endmodule
